// ===== hdl/tkbo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkbo_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_ACCEPT    = 5'd1;
  localparam op_t OP_LOAD_RD   = 5'd2;
  localparam op_t OP_LOAD_WR   = 5'd3;
  localparam op_t OP_FETCH_RD  = 5'd4;
  localparam op_t OP_FETCH_OUT = 5'd5;
  localparam op_t OP_WALK_INIT = 5'd6;
  localparam op_t OP_HEAD_RD   = 5'd7;
  localparam op_t OP_HEAD_TAKE = 5'd8;
  localparam op_t OP_NODE      = 5'd9;
  localparam op_t OP_LINK_TAKE = 5'd10;
  localparam op_t OP_NEXT_K    = 5'd11;
  localparam op_t OP_R_INIT    = 5'd12;
  localparam op_t OP_R_MID     = 5'd13;
  localparam op_t OP_R_SP      = 5'd14;
  localparam op_t OP_R_HD      = 5'd15;
  localparam op_t OP_R_WR      = 5'd16;
  localparam op_t OP_SORT_DONE = 5'd17;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_KEY = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    op_t  op;
    logic pass;   // 0: walk into middle order, 1: walk into final order
  } cmd_t;

  typedef struct packed {
    logic p_nz;
    logic n_lt_count;
    logic k_last;
    logic i_zero;
    logic last_r;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/tkbo_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkbo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tkbo_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkbo_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  input  wire logic          out_valid,
  input  wire logic          out_ready,
  input  wire tkbo_pkg::sts_t sts,
  output logic               in_ready,
  output tkbo_pkg::cmd_t     cmd
);
  import tkbo_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_LOADW  = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_FETCHO = 4'd4;
  localparam logic [3:0] S_WINIT  = 4'd5;
  localparam logic [3:0] S_WHRD   = 4'd6;
  localparam logic [3:0] S_WHTK   = 4'd7;
  localparam logic [3:0] S_WNODE  = 4'd8;
  localparam logic [3:0] S_WLTK   = 4'd9;
  localparam logic [3:0] S_RINIT  = 4'd10;
  localparam logic [3:0] S_RMID   = 4'd11;
  localparam logic [3:0] S_RSP    = 4'd12;
  localparam logic [3:0] S_RHD    = 4'd13;
  localparam logic [3:0] S_RWR    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0] state, state_next;
  logic       pass, pass_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd.op     = OP_NONE;
    cmd.pass   = pass;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op     = OP_ACCEPT;
          state_next = in_action ? S_FETCH : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD_RD;
        state_next = S_LOADW;
      end
      S_LOADW: begin
        cmd.op = OP_LOAD_WR;
        if (sts.last_r) begin
          pass_next  = 1'b0;
          state_next = S_WINIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.op     = OP_FETCH_RD;
        state_next = S_FETCHO;
      end
      S_FETCHO: begin
        cmd.op     = OP_FETCH_OUT;
        state_next = S_IDLE;
      end
      S_WINIT: begin
        cmd.op     = OP_WALK_INIT;
        state_next = S_WHRD;
      end
      S_WHRD: begin
        cmd.op     = OP_HEAD_RD;
        state_next = S_WHTK;
      end
      S_WHTK: begin
        cmd.op     = OP_HEAD_TAKE;
        state_next = S_WNODE;
      end
      S_WNODE: begin
        if (sts.p_nz && sts.n_lt_count) begin
          cmd.op     = OP_NODE;
          state_next = S_WLTK;
        end else begin
          cmd.op = OP_NEXT_K;
          if (sts.k_last) begin
            state_next = pass ? S_DONE : S_RINIT;
          end else begin
            state_next = S_WHRD;
          end
        end
      end
      S_WLTK: begin
        cmd.op     = OP_LINK_TAKE;
        state_next = S_WNODE;
      end
      S_RINIT: begin
        cmd.op     = OP_R_INIT;
        state_next = S_RMID;
      end
      S_RMID: begin
        if (sts.i_zero) begin
          pass_next  = 1'b1;
          state_next = S_WINIT;
        end else begin
          cmd.op     = OP_R_MID;
          state_next = S_RSP;
        end
      end
      S_RSP: begin
        cmd.op     = OP_R_SP;
        state_next = S_RHD;
      end
      S_RHD: begin
        cmd.op     = OP_R_HD;
        state_next = S_RWR;
      end
      S_RWR: begin
        cmd.op     = OP_R_WR;
        state_next = S_RMID;
      end
      S_DONE: begin
        cmd.op     = OP_SORT_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted transaction did not start");

  // the sort only finishes after the second walk
  a_done_pass: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> pass)
    else $error("sort finished after first walk");

endmodule

`default_nettype wire

// ===== hdl/tkbo_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkbo_dp #(
  parameter int MAX_ITEMS = 1024,
  parameter int KEY_LIMIT = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tkbo_pkg::cmd_t cmd,
  input  wire logic [7:0]     max_key,
  input  wire logic           action,
  input  wire logic [7:0]     primary_key,
  input  wire logic [7:0]     secondary_key,
  input  wire logic           last_item,
  input  wire logic           out_ready,
  output tkbo_pkg::sts_t      sts,
  output logic                out_valid,
  output logic [9:0]          item_position,
  output logic                last_of_run,
  output logic [1:0]          status
);
  import tkbo_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int NB = (KEY_LIMIT < 256) ? KEY_LIMIT : 256;
  localparam int KW = $clog2(NB);

  logic [7:0]    pk_r, sk_r;
  logic          last_r;
  logic [CW-1:0] count, fp, p, n, i;
  logic          fetching;
  logic [KW-1:0] k, key;
  logic [AW-1:0] e;
  logic [NB-1:0] head_vld;

  logic          bad_key, full, ld_ok, fetch_ok;
  logic          out_set;
  logic [KW-1:0] sk_idx, hidx;
  logic [CW-1:0] p_m1_w, i_m1_w, head_eff;
  logic [AW-1:0] p_m1, i_m1;

  logic          sp_we, lk_we, hd_we, md_we, fn_we;
  logic [AW-1:0] lk_waddr;
  logic [KW-1:0] hd_raddr;
  logic [CW-1:0] hd_wdata;
  logic [7:0]    sp_rd;
  logic [CW-1:0] lk_rd, hd_rd;
  logic [AW-1:0] md_rd, fn_rd;

  assign bad_key = (pk_r > max_key) || (sk_r > max_key) ||
                   (32'(pk_r) >= 32'(KEY_LIMIT)) || (32'(sk_r) >= 32'(KEY_LIMIT));
  assign full     = (count == CW'(MAX_ITEMS));
  assign ld_ok    = !bad_key && !full;
  assign fetch_ok = fetching && (fp < count);
  assign sk_idx   = sk_r[KW-1:0];
  assign hidx     = (cmd.op == OP_LOAD_WR) ? sk_idx : key;
  assign head_eff = head_vld[hidx] ? hd_rd : '0;
  assign p_m1_w   = p - CW'(1);
  assign i_m1_w   = i - CW'(1);
  assign p_m1     = p_m1_w[AW-1:0];
  assign i_m1     = i_m1_w[AW-1:0];

  // result register is loaded on these steps
  assign out_set  = ((cmd.op == OP_LOAD_WR) && !last_r) ||
                    (cmd.op == OP_FETCH_OUT) || (cmd.op == OP_SORT_DONE);

  assign sts.p_nz       = (p != '0);
  assign sts.n_lt_count = (n < count);
  assign sts.k_last     = (k == KW'(NB - 1));
  assign sts.i_zero     = (i == '0);
  assign sts.last_r     = last_r;

  // memory port steering
  assign sp_we    = (cmd.op == OP_LOAD_WR) && ld_ok;
  assign lk_we    = sp_we || (cmd.op == OP_R_WR);
  assign hd_we    = lk_we;
  assign lk_waddr = (cmd.op == OP_LOAD_WR) ? count[AW-1:0] : e;
  assign hd_wdata = (cmd.op == OP_LOAD_WR) ? count + CW'(1) : CW'(e) + CW'(1);
  assign md_we    = (cmd.op == OP_NODE) && !cmd.pass;
  assign fn_we    = (cmd.op == OP_NODE) && cmd.pass;

  always_comb begin
    unique case (cmd.op)
      OP_LOAD_RD: hd_raddr = sk_idx;
      OP_HEAD_RD: hd_raddr = k;
      default:    hd_raddr = sp_rd[KW-1:0];
    endcase
  end

  tkbo_ram #(.WIDTH(8), .DEPTH(MAX_ITEMS)) u_sp (
    .clk(clk), .we(sp_we), .waddr(count[AW-1:0]), .wdata(pk_r),
    .raddr(md_rd), .rdata(sp_rd)
  );

  tkbo_ram #(.WIDTH(CW), .DEPTH(MAX_ITEMS)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(head_eff),
    .raddr(p_m1), .rdata(lk_rd)
  );

  tkbo_ram #(.WIDTH(CW), .DEPTH(NB)) u_head (
    .clk(clk), .we(hd_we), .waddr(hidx), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rd)
  );

  tkbo_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_mid (
    .clk(clk), .we(md_we), .waddr(n[AW-1:0]), .wdata(p_m1),
    .raddr(i_m1), .rdata(md_rd)
  );

  tkbo_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_fin (
    .clk(clk), .we(fn_we), .waddr(n[AW-1:0]), .wdata(p_m1),
    .raddr(fp[AW-1:0]), .rdata(fn_rd)
  );

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        pk_r   <= primary_key;
        sk_r   <= secondary_key;
        last_r <= last_item;
      end
      OP_LOAD_WR: begin
        item_position <= ld_ok ? 10'(count[AW-1:0]) : '0;
        last_of_run   <= 1'b0;
        status        <= bad_key ? ST_BAD_KEY : (full ? ST_FULL : ST_OK);
      end
      OP_FETCH_OUT: begin
        item_position <= fetch_ok ? 10'(fn_rd) : '0;
        last_of_run   <= fetch_ok && ((fp + CW'(1)) == count);
        status        <= fetch_ok ? ST_OK : ST_EMPTY;
      end
      OP_WALK_INIT: begin
        k <= '0;
        n <= '0;
      end
      OP_HEAD_TAKE: p <= head_vld[k] ? hd_rd : '0;
      OP_NODE:      n <= n + CW'(1);
      OP_LINK_TAKE: p <= lk_rd;
      OP_NEXT_K:    k <= k + KW'(1);
      OP_R_INIT:    i <= count;
      OP_R_SP:      e <= md_rd;
      OP_R_HD:      key <= sp_rd[KW-1:0];
      OP_R_WR:      i <= i - CW'(1);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fp        <= '0;
      fetching  <= 1'b0;
      head_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (!action && fetching) begin
            head_vld <= '0;
            count    <= '0;
            fp       <= '0;
            fetching <= 1'b0;
          end
        end
        OP_LOAD_WR: begin
          if (ld_ok) begin
            count            <= count + CW'(1);
            head_vld[sk_idx] <= 1'b1;
          end
        end
        OP_FETCH_OUT: begin
          if (fetch_ok) begin
            fp <= fp + CW'(1);
          end
        end
        OP_HEAD_TAKE: head_vld[k] <= 1'b0;
        OP_R_WR:      head_vld[key] <= 1'b1;
        OP_SORT_DONE: begin
          fetching  <= 1'b1;
          fp        <= '0;
        end
        default: ;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count past capacity");

  a_fp_range: assert property (@(posedge clk) disable iff (rst)
    fetching |-> fp <= count)
    else $error("fetch pointer past item count");

  a_node_room: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_NODE |-> n < count)
    else $error("bucket walk emitted too many items");

endmodule

`default_nettype wire

// ===== hdl/two_key_bucket_order.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    action, primary_key, secondary_key, last_item
// out       out  out_valid/out_ready  item_position, last_of_run, status
// config    in   APB psel/penable     max_key at byte address 0
//
// Loads and fetches are taken one transaction at a time.
// The load marked last_item also runs the sort before its result shows:
// a bucket walk into the middle order, a rebucketing pass, then a second
// walk into the final order; every step waits on a registered memory
// read, following bucket links one node at a time.
// Reset (rst, synchronous) empties the data set; the bucket heads carry
// valid flops so no clearing pass is needed.
// A waiting result is parted from the input by the output register; a new
// transaction is taken once that register is empty or being drained.

module two_key_bucket_order #(
  parameter int MAX_ITEMS = 1024,
  parameter int KEY_LIMIT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  primary_key,
  input  wire logic [7:0]  secondary_key,
  input  wire logic        last_item,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       item_position,
  output logic             last_of_run,
  output logic [1:0]       status,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tkbo_pkg::*;

  logic [7:0] max_key;
  cmd_t       cmd;
  sts_t       sts;

  // single register: max_key at addresses 0 to 3 (paddr[2] low), 4 to 7 read zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'b0, max_key} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_key <= 8'd255;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_key <= pwdata[7:0];
    end
  end

  // sequencer: steps loads, fetches and the two bucket passes
  tkbo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // datapath: bucket memories, counters and the result register
  tkbo_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_LIMIT (KEY_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .max_key       (max_key),
    .action        (action),
    .primary_key   (primary_key),
    .secondary_key (secondary_key),
    .last_item     (last_item),
    .out_ready     (out_ready),
    .sts           (sts),
    .out_valid     (out_valid),
    .item_position (item_position),
    .last_of_run   (last_of_run),
    .status        (status)
  );

endmodule

`default_nettype wire
